// ===== sv/opsm_pkg.sv =====
// Shared types, constants and the pilot polarity table of the OFDM pilot subcarrier mapper.
// No dependencies; every other file imports this package.
package opsm_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int NUM_TONES    = 48;
    localparam int SEQ_LEN      = 127;
    localparam int QUEUE_DEPTH  = 4;

    localparam int TONE_W = 6;
    localparam int IDX_W  = 7;

    localparam logic [TONE_W-1:0] TONE_FIRST     = TONE_W'(0);
    localparam logic [TONE_W-1:0] TONE_PILOT0    = TONE_W'(5);
    localparam logic [TONE_W-1:0] TONE_PILOT1    = TONE_W'(18);
    localparam logic [TONE_W-1:0] TONE_DC        = TONE_W'(24);
    localparam logic [TONE_W-1:0] TONE_PILOT2    = TONE_W'(30);
    localparam logic [TONE_W-1:0] TONE_PILOT_INV = TONE_W'(43);
    localparam logic [TONE_W-1:0] TONE_LAST      = TONE_W'(NUM_TONES - 1);

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SEQ_LEN - 1);

    localparam logic signed [SAMPLE_WIDTH-1:0] PILOT_POS =
        SAMPLE_WIDTH'(1 << (SAMPLE_WIDTH - 2));
    localparam logic signed [SAMPLE_WIDTH-1:0] PILOT_NEG =
        SAMPLE_WIDTH'(-(1 << (SAMPLE_WIDTH - 2)));

    // bins emitted ahead of the data bin
    typedef logic [1:0] t_pre;
    localparam t_pre PRE_NONE  = 2'd0;
    localparam t_pre PRE_GUARD = 2'd1;
    localparam t_pre PRE_PILOT = 2'd2;
    localparam t_pre PRE_DC    = 2'd3;

    localparam logic [3:0] GUARD_LO_BINS = 4'd6;
    localparam logic [3:0] GUARD_HI_BINS = 4'd5;

    // entry 0 is the leftmost bit; 1 marks a negative polarity
    localparam logic [0:SEQ_LEN-1] SEQ_NEG = {
        16'b0000111011110010, 16'b1100100100000010,
        16'b0010011000101110, 16'b1011011000001100,
        16'b1101010011100111, 16'b1011010000101010,
        16'b1111101001010001, 15'b101110001111111
    };

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] data_real;
        logic signed [SAMPLE_WIDTH-1:0] data_imag;
        logic                           frame_start;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] bin_real;
        logic signed [SAMPLE_WIDTH-1:0] bin_imag;
        logic                           bin_last;
    } t_out_item;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] data_real;
        logic signed [SAMPLE_WIDTH-1:0] data_imag;
        t_pre                           pre_kind;
        logic                           pilot_neg;
        logic                           tail;
    } t_cmd;

    function automatic logic seq_negative(input logic [IDX_W-1:0] idx);
        seq_negative = SEQ_NEG[idx];
    endfunction

endpackage

// ===== sv/opsm_front.sv =====
// Front end of the mapper: accepts data tones, tracks tone position and pilot index,
// and turns each tone into a mapping command. Depends on opsm_pkg.
module opsm_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    input  opsm_pkg::t_in_item i_item,
    input  logic              i_q_full,
    output logic              full,
    output logic              o_q_wr,
    output opsm_pkg::t_cmd    o_cmd
);
    import opsm_pkg::*;

    logic [TONE_W-1:0] r_tone_pos, n_tone_pos;
    logic [IDX_W-1:0]  r_pilot_idx, n_pilot_idx;
    logic [TONE_W-1:0] pos;
    logic [IDX_W-1:0]  idx;
    logic              accept;

    assign full   = i_q_full;
    assign accept = push && !i_q_full;
    assign o_q_wr = accept;

    always_comb begin
        pos = (r_tone_pos > TONE_LAST) ? TONE_FIRST : r_tone_pos;
        idx = (r_pilot_idx > IDX_LAST) ? '0 : r_pilot_idx;
        if (pos == TONE_FIRST && i_item.frame_start) begin
            idx = '0;
        end

        o_cmd.data_real = i_item.data_real;
        o_cmd.data_imag = i_item.data_imag;
        o_cmd.pilot_neg = seq_negative(idx) ^ (pos == TONE_PILOT_INV);
        o_cmd.tail      = (pos == TONE_LAST);
        case (pos)
            TONE_FIRST:     o_cmd.pre_kind = PRE_GUARD;
            TONE_PILOT0,
            TONE_PILOT1,
            TONE_PILOT2,
            TONE_PILOT_INV: o_cmd.pre_kind = PRE_PILOT;
            TONE_DC:        o_cmd.pre_kind = PRE_DC;
            default:        o_cmd.pre_kind = PRE_NONE;
        endcase

        if (pos == TONE_LAST) begin
            n_tone_pos  = TONE_FIRST;
            n_pilot_idx = (idx == IDX_LAST) ? '0 : idx + IDX_W'(1);
        end else begin
            n_tone_pos  = pos + TONE_W'(1);
            n_pilot_idx = idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tone_pos  <= '0;
            r_pilot_idx <= '0;
        end else if (accept) begin
            r_tone_pos  <= n_tone_pos;
            r_pilot_idx <= n_pilot_idx;
        end
    end

    a_tone_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tone_pos <= TONE_LAST)
        else $error("tone position out of range");

endmodule

// ===== sv/opsm_queue.sv =====
// Command queue between the mapper front end and back end.
// Depends on opsm_pkg for the command type.
module opsm_queue #(
    parameter int DEPTH = opsm_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  opsm_pkg::t_cmd i_cmd,
    input  logic           i_rd,
    output logic           o_full,
    output logic           o_valid,
    output opsm_pkg::t_cmd o_cmd
);
    import opsm_pkg::*;

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    t_cmd              r_mem [DEPTH];
    logic [ADDR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= (r_wr_ptr == ADDR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + ADDR_W'(1);
            end
            if (i_rd) begin
                r_rd_ptr <= (r_rd_ptr == ADDR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + ADDR_W'(1);
            end
            case ({i_wr, i_rd})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |-> !o_full)
        else $error("write into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd |-> o_valid)
        else $error("read from empty queue");

endmodule

// ===== sv/opsm_back.sv =====
// Back end of the mapper: expands each command into its frequency bins, one bin per
// cycle into an output register while it is empty or popped. Depends on opsm_pkg.
module opsm_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  opsm_pkg::t_cmd     i_cmd,
    output logic               o_cmd_pop,
    input  logic               pop,
    output logic               empty,
    output opsm_pkg::t_out_item o_item
);
    import opsm_pkg::*;

    logic [3:0] r_step;
    logic       r_valid;
    t_out_item  r_out, n_out;
    logic [3:0] pre_cnt, last_step;
    logic       load, cmd_end;

    assign empty  = !r_valid;
    assign o_item = r_out;
    assign load   = i_cmd_valid && (!r_valid || pop);
    assign cmd_end   = (r_step == last_step);
    assign o_cmd_pop = load && cmd_end;

    always_comb begin
        case (i_cmd.pre_kind)
            PRE_GUARD: pre_cnt = GUARD_LO_BINS;
            PRE_PILOT,
            PRE_DC:    pre_cnt = 4'd1;
            default:   pre_cnt = 4'd0;
        endcase
        last_step = pre_cnt + (i_cmd.tail ? GUARD_HI_BINS : 4'd0);

        n_out.bin_real = '0;
        n_out.bin_imag = '0;
        n_out.bin_last = 1'b0;
        if (r_step < pre_cnt) begin
            if (i_cmd.pre_kind == PRE_PILOT) begin
                n_out.bin_real = i_cmd.pilot_neg ? PILOT_NEG : PILOT_POS;
            end
        end else if (r_step == pre_cnt) begin
            n_out.bin_real = i_cmd.data_real;
            n_out.bin_imag = i_cmd.data_imag;
        end else begin
            n_out.bin_last = cmd_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_step  <= cmd_end ? '0 : r_step + 4'd1;
            end else if (pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid |-> r_step <= last_step)
        else $error("bin step beyond command end");

    a_idle_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd_valid |-> r_step == '0)
        else $error("partial command lost");

    a_last_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load && n_out.bin_last |-> i_cmd.tail && o_cmd_pop)
        else $error("last bin outside symbol end");

endmodule

// ===== sv/ofdm_pilot_subcarrier_mapper.sv =====
// OFDM pilot insertion and subcarrier mapping: 48 data tones in, 64 frequency bins out.
// Depends on opsm_pkg, opsm_front, opsm_queue and opsm_back.
//
// Input channel: present a data tone on i_item and raise push; it transfers on a
// rising edge with push high and full low. frame_start on a symbol's first tone
// restarts the pilot polarity sequence; elsewhere it has no effect.
// Output channel: while empty is low, o_item holds the oldest bin; it transfers on
// a rising edge with pop high. bin_last marks bin 63 of each symbol.
// A tone's command enters the queue; its first bin then goes into the output register.
// Throughput: one bin per cycle from the output register while the receiver pops, so
// a symbol yields 64 bins for its 48 tones; a tone yields one bin, the first tone of a
// symbol seven, a pilot or DC neighbor two, the last tone six. The input side runs
// ahead through a QUEUE_DEPTH-entry command queue and raises full only when it fills.
// Reset: synchronous, active low; clears tone position, pilot index, queue and
// output valid flag. A stalled receiver holds the current bin; the queue fills and
// then full holds the sender.
module ofdm_pilot_subcarrier_mapper #(
    parameter int QUEUE_DEPTH = opsm_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  opsm_pkg::t_in_item  i_item,
    output logic                empty,
    input  logic                pop,
    output opsm_pkg::t_out_item o_item
);
    import opsm_pkg::*;

    t_cmd front_cmd, q_cmd;
    logic q_wr, q_full, q_valid, q_rd;

    opsm_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .i_item   (i_item),
        .i_q_full (q_full),
        .full     (full),
        .o_q_wr   (q_wr),
        .o_cmd    (front_cmd)
    );

    opsm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_cmd   (front_cmd),
        .i_rd    (q_rd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    opsm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_rd),
        .pop         (pop),
        .empty       (empty),
        .o_item      (o_item)
    );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Testbench for ofdm_pilot_subcarrier_mapper: streams data tones and checks every bin
// against a built-in pilot/guard/DC mapping predictor. Depends on opsm_pkg and the RTL.
module tb;
    import opsm_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 20;
    localparam int PRINT_LIMIT  = 100;
    localparam int POLARITY_LEN = 127;

    localparam logic [5:0] TONE_OPEN      = 6'd0;
    localparam logic [5:0] TONE_PILOT_A   = 6'd5;
    localparam logic [5:0] TONE_PILOT_B   = 6'd18;
    localparam logic [5:0] TONE_NEAR_DC   = 6'd24;
    localparam logic [5:0] TONE_PILOT_C   = 6'd30;
    localparam logic [5:0] TONE_PILOT_INV = 6'd43;
    localparam logic [5:0] TONE_CLOSE     = 6'd47;
    localparam logic [6:0] POLARITY_END   = 7'(POLARITY_LEN - 1);

    localparam logic signed [SAMPLE_WIDTH-1:0] ONE_Q14 = SAMPLE_WIDTH'(1 << (SAMPLE_WIDTH - 2));
    // 1 marks a negative pilot; entry 0 is leftmost
    localparam logic [0:POLARITY_LEN-1] POLARITY_NEG = {
        16'b0000111011110010, 16'b1100100100000010,
        16'b0010011000101110, 16'b1011011000001100,
        16'b1101010011100111, 16'b1011010000101010,
        16'b1111101001010001, 15'b101110001111111
    };

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push = 1'b0;
    logic      pop = 1'b0;
    logic      full;
    logic      empty;
    t_in_item  i_item = '0;
    t_out_item o_item;

    t_out_item bins_due[$];
    logic [5:0] tone_pos = '0;
    logic [6:0] pilot_idx = '0;

    int fail_count = 0;
    int bin_seen = 0;
    int idle_cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_req = 0;
    int hold_left = 0;

    ofdm_pilot_subcarrier_mapper uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .empty   (empty),
        .pop     (pop),
        .o_item  (o_item)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_out_item pilot_bin(input logic invert);
        t_out_item b;
        b = '0;
        b.bin_real = (POLARITY_NEG[pilot_idx] ^ invert) ? -ONE_Q14 : ONE_Q14;
        return b;
    endfunction

    task automatic map_tone(input t_in_item t);
        t_out_item b;
        int k;
        b = '0;
        if (tone_pos == TONE_OPEN && t.frame_start)
            pilot_idx = '0;
        if (tone_pos == TONE_OPEN) begin
            for (k = 0; k < 6; k++)
                bins_due.push_back(b);
        end else if (tone_pos == TONE_PILOT_A || tone_pos == TONE_PILOT_B ||
                     tone_pos == TONE_PILOT_C) begin
            bins_due.push_back(pilot_bin(1'b0));
        end else if (tone_pos == TONE_PILOT_INV) begin
            bins_due.push_back(pilot_bin(1'b1));
        end else if (tone_pos == TONE_NEAR_DC) begin
            bins_due.push_back(b);
        end
        b.bin_real = t.data_real;
        b.bin_imag = t.data_imag;
        bins_due.push_back(b);
        if (tone_pos == TONE_CLOSE) begin
            b = '0;
            for (k = 0; k < 5; k++) begin
                b.bin_last = (k == 4);
                bins_due.push_back(b);
            end
            pilot_idx = (pilot_idx == POLARITY_END) ? '0 : pilot_idx + 7'd1;
            tone_pos = TONE_OPEN;
        end else begin
            tone_pos = tone_pos + 6'd1;
        end
    endtask

    function automatic t_in_item make_tone(input int re, input int im, input logic fs);
        t_in_item t;
        t.data_real = SAMPLE_WIDTH'(re);
        t.data_imag = SAMPLE_WIDTH'(im);
        t.frame_start = fs;
        return t;
    endfunction

    function automatic t_in_item random_tone(input logic fs);
        return make_tone(int'($urandom), int'($urandom), fs);
    endfunction

    // push stays high on return so back-to-back transfers need no second drive
    task automatic send_tone(input t_in_item t);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_item <= t;
        do @(posedge i_clk); while (full);
        map_tone(t);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        do @(posedge i_clk); while (bins_due.size() != 0);
    endtask

    task automatic log_mismatch(input string what);
        if (fail_count < PRINT_LIMIT)
            $display("mismatch at bin %0d: %s", bin_seen, what);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    t_out_item want;
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (bins_due.size() == 0) begin
                log_mismatch("bin transfer with nothing expected");
            end else begin
                want = bins_due.pop_front();
                if (o_item.bin_real !== want.bin_real)
                    log_mismatch($sformatf("bin_real got %0d want %0d",
                                           o_item.bin_real, want.bin_real));
                if (o_item.bin_imag !== want.bin_imag)
                    log_mismatch($sformatf("bin_imag got %0d want %0d",
                                           o_item.bin_imag, want.bin_imag));
                if (o_item.bin_last !== want.bin_last)
                    log_mismatch($sformatf("bin_last got %0b want %0b",
                                           o_item.bin_last, want.bin_last));
            end
            bin_seen++;
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty && bins_due.size() != 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // extremes, pilots at tones 5 and 18, DC neighbor, ignored mid-symbol frame start
    task automatic test_directed();
        int k;
        int re;
        int im;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (k = 0; k <= int'(TONE_NEAR_DC); k++) begin
            case (k % 4)
                0: begin re = -32768; im = 32767; end
                1: begin re = 32767; im = -32768; end
                2: begin re = 0; im = -1; end
                default: begin re = -1; im = 0; end
            endcase
            send_tone(make_tone(re, im, k == 0 || k == 3 || k == int'(TONE_PILOT_B)));
        end
        wait_drained();
    endtask

    task automatic test_random(input int send_pct, input int recv_pct, input int count);
        int k;
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        for (k = 0; k < count; k++)
            send_tone(random_tone($urandom_range(15) == 0));
        wait_drained();
    endtask

    // receiver holds off so the block fills and raises full
    task automatic test_backpressure();
        int k;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = HOLD_CYCLES;
        for (k = 0; k < 40; k++)
            send_tone(random_tone($urandom_range(7) == 0));
        wait_drained();
    endtask

    // one whole symbol with frame start only off the first tone
    task automatic test_mid_frame_start();
        int k;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        while (tone_pos != TONE_OPEN)
            send_tone(random_tone(1'b0));
        for (k = 0; k < NUM_TONES; k++)
            send_tone(random_tone((k != 0) && $urandom_range(1)));
        wait_drained();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(0, 0, 50);
        test_random(65, 0, 50);
        test_random(0, 65, 50);
        test_random(27, 27, 50);
        test_backpressure();
        test_mid_frame_start();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && bins_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/opsm_pkg.sv
sv/opsm_front.sv
sv/opsm_queue.sv
sv/opsm_back.sv
sv/ofdm_pilot_subcarrier_mapper.sv
tb/tb.sv
